// File: hw/rtl/hmm_viterbi_decoder_defines.svh
// assertion macros for the hmm viterbi decoder
`ifndef HMM_VITERBI_DECODER_DEFINES_SVH
`define HMM_VITERBI_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HVD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hvd_pkg.sv
// shared codes and controller/datapath interface types for the viterbi decoder
`default_nettype none

package hvd_pkg;

    localparam logic [1:0] FUNC_TRANS = 2'd0;
    localparam logic [1:0] FUNC_EMIS  = 2'd1;
    localparam logic [1:0] FUNC_PRIOR = 2'd2;
    localparam logic [1:0] FUNC_PUSH  = 2'd3;

    localparam logic signed [31:0] FLOOR_RESET = -32'sd46425440;

    typedef struct packed {
        logic clr_en;
        logic load_en;
        logic push_take;
        logic set_ovf;
        logic acs_issue;
        logic word_done;
        logic scan_issue;
        logic bt_init;
        logic bt_rd;
        logic bt_step;
        logic em_rd;
        logic em_load;
        logic out_take;
        logic em_next;
        logic sent_done;
    } hvd_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic wc_full;
        logic acs_last;
        logic scan_last;
        logic pipe_busy;
        logic end_flag;
        logic bt_last;
        logic em_last;
    } hvd_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/hvd_ctrl.sv
// sequencing state machine of the viterbi decoder
`default_nettype none

module hvd_ctrl
    import hvd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic        sentence_end,
    input  wire logic        out_stall,
    input  wire hvd_status_t status,
    output hvd_cmd_t         cmd
);

    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_ACS        = 4'd2;
    localparam logic [3:0] S_ACS_DRAIN  = 4'd3;
    localparam logic [3:0] S_SCAN       = 4'd4;
    localparam logic [3:0] S_SCAN_DRAIN = 4'd5;
    localparam logic [3:0] S_BT_RD      = 4'd6;
    localparam logic [3:0] S_BT_WAIT    = 4'd7;
    localparam logic [3:0] S_EM_RD      = 4'd8;
    localparam logic [3:0] S_EM_LOAD    = 4'd9;
    localparam logic [3:0] S_EM_OUT     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_PUSH)
                    begin
                        cmd.push_take = 1'b1;
                        if (!status.wc_full)
                        begin
                            state_next = S_ACS;
                        end
                        else
                        begin
                            cmd.set_ovf = 1'b1;
                            if (sentence_end)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        cmd.load_en = 1'b1;
                    end
                end
            end
            S_ACS:
            begin
                cmd.acs_issue = 1'b1;
                if (status.acs_last)
                begin
                    state_next = S_ACS_DRAIN;
                end
            end
            S_ACS_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.word_done = 1'b1;
                    state_next    = status.end_flag ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.bt_init = 1'b1;
                    state_next  = S_BT_RD;
                end
            end
            S_BT_RD:
            begin
                cmd.bt_rd  = 1'b1;
                state_next = status.bt_last ? S_EM_RD : S_BT_WAIT;
            end
            S_BT_WAIT:
            begin
                cmd.bt_step = 1'b1;
                state_next  = S_BT_RD;
            end
            S_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = S_EM_LOAD;
            end
            S_EM_LOAD:
            begin
                cmd.em_load = 1'b1;
                state_next  = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (!out_stall)
                begin
                    cmd.out_take = 1'b1;
                    if (status.em_last)
                    begin
                        cmd.sent_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.em_next = 1'b1;
                        state_next  = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hvd_datapath.sv
// tables, add-compare-select pipeline, backtrace and result register of the decoder
`default_nettype none

module hvd_datapath
    import hvd_pkg::*;
#(
    parameter int NUM_TAGS    = 64,
    parameter int VOCAB_SIZE  = 4096,
    parameter int MAX_WORDS   = 64,
    parameter int SCORE_WIDTH = 48
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hvd_cmd_t           cmd,
    output hvd_status_t             status,
    input  wire logic               cfg_valid,
    input  wire logic signed [31:0] cfg_data,
    input  wire logic [1:0]         func,
    input  wire logic [5:0]         current_tag,
    input  wire logic [5:0]         previous_tag,
    input  wire logic [11:0]        word_index,
    input  wire logic signed [31:0] log_prob,
    input  wire logic               sentence_end,
    output logic                    out_valid,
    output logic [5:0]              tag_index,
    output logic [5:0]              word_pos,
    output logic                    last_tag,
    output logic                    length_overflow
);

    localparam int SW   = SCORE_WIDTH;
    localparam int TW   = $clog2(NUM_TAGS);
    localparam int WW   = $clog2(VOCAB_SIZE);
    localparam int PW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW   = $clog2(MAX_WORDS + 1);
    localparam int EW   = TW + WW;
    localparam int TRW  = 2 * TW;
    localparam int CLRW = (EW > TRW) ? EW : TRW;

    localparam logic [TW-1:0] LAST_TAG = TW'(NUM_TAGS - 1);
    localparam logic signed [SW-1:0] SCORE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SCORE_MIN = {1'b1, {(SW-1){1'b0}}};

    // table entries carry a written flag above the value
    logic [32:0]            tr_mem [2**TRW];
    logic [32:0]            em_mem [2**EW];
    logic [32:0]            pr_mem [2**EW];
    logic signed [SW-1:0]   pa_mem [2**(TW+1)];
    logic [TW-1:0]          bp_mem [2**(PW+TW)];
    logic [TW-1:0]          tb_mem [2**PW];

    logic signed [31:0] floor_reg;
    logic [CLRW-1:0]    clr_reg;
    logic [CW-1:0]      wc_reg;
    logic               ovf_reg;
    logic [WW-1:0]      word_reg;
    logic               known_reg;
    logic               end_reg;
    logic [TW-1:0]      j_reg;
    logic [TW-1:0]      k_reg;

    logic [32:0]          tr_rd_reg;
    logic [32:0]          em_rd_reg;
    logic [32:0]          pr_rd_reg;
    logic signed [SW-1:0] pa_rd_reg;
    logic [TW-1:0]        bp_rd_reg;
    logic [TW-1:0]        tb_rd_reg;

    logic          v1_reg, l1_reg, f1_reg;
    logic [TW-1:0] j1_reg, k1_reg;
    logic          v2_reg, l2_reg, f2_reg;
    logic [TW-1:0] j2_reg, k2_reg;
    logic          v3_reg, l3_reg, f3_reg;
    logic [TW-1:0] j3_reg, k3_reg;
    logic          sv1_reg, sf1_reg;
    logic [TW-1:0] sk1_reg;

    logic signed [32:0]   te_reg;
    logic signed [SW-1:0] pa2_reg;
    logic signed [31:0]   pr2_reg;
    logic signed [SW-1:0] t_reg;
    logic signed [SW-1:0] best_reg;
    logic [TW-1:0]        arg_reg;
    logic signed [SW-1:0] mx_reg;
    logic [TW-1:0]        tag_reg;
    logic [PW-1:0]        p_reg;
    logic [PW-1:0]        e_reg;

    logic       out_valid_reg;
    logic [5:0] tag_index_reg;
    logic [5:0] word_pos_reg;
    logic       last_tag_reg;
    logic       ovf_out_reg;

    logic            ctag_ok, ptag_ok, word_ok;
    logic [TW-1:0]   ctag_a, ptag_a;
    logic [WW-1:0]   word_a;
    logic            tr_we, em_we, pr_we;
    logic [TRW-1:0]  tr_waddr;
    logic [EW-1:0]   tb_waddr_e;
    logic [32:0]     wdata;
    logic [CW-1:0]   wc_m1;
    logic            wc_zero;
    logic            k_last;
    logic [TW:0]     pa_raddr;
    logic signed [31:0]   tr_v, em_v, pr_v;
    logic signed [SW:0]   sum_w;
    logic signed [SW-1:0] sat_v;
    logic signed [SW-1:0] t_next;
    logic                 take;
    logic signed [SW-1:0] nbest;
    logic [TW-1:0]        narg;
    logic                 stake;
    logic signed [SW-1:0] nmx;
    logic [TW-1:0]        nsarg;

    assign ctag_ok  = {3'b000, current_tag} < 9'(NUM_TAGS);
    assign ptag_ok  = {3'b000, previous_tag} < 9'(NUM_TAGS);
    assign word_ok  = {5'b00000, word_index} < 17'(VOCAB_SIZE);
    assign ctag_a   = TW'(current_tag);
    assign ptag_a   = TW'(previous_tag);
    assign word_a   = WW'(word_index);
    assign wdata    = cmd.clr_en ? 33'd0 : {1'b1, log_prob};

    assign tr_we = cmd.clr_en | (cmd.load_en & (func == FUNC_TRANS) & ctag_ok & ptag_ok);
    assign em_we = cmd.clr_en | (cmd.load_en & (func == FUNC_EMIS) & ctag_ok & word_ok);
    assign pr_we = cmd.clr_en | (cmd.load_en & (func == FUNC_PRIOR) & ctag_ok & word_ok);
    assign tr_waddr   = cmd.clr_en ? clr_reg[TRW-1:0] : {ctag_a, ptag_a};
    assign tb_waddr_e = cmd.clr_en ? clr_reg[EW-1:0] : {ctag_a, word_a};

    assign wc_m1   = wc_reg - CW'(1);
    assign wc_zero = (wc_reg == '0);
    assign k_last  = wc_zero | (k_reg == LAST_TAG);
    // acs reads the other bank, the final scan reads the bank of the last word
    assign pa_raddr = cmd.scan_issue ? {wc_m1[0], k_reg} : {~wc_reg[0], k_reg};

    assign status.clr_last  = (clr_reg == '1);
    assign status.wc_full   = (wc_reg == CW'(MAX_WORDS));
    assign status.acs_last  = k_last & (j_reg == LAST_TAG);
    assign status.scan_last = (k_reg == LAST_TAG);
    assign status.pipe_busy = v1_reg | v2_reg | v3_reg | sv1_reg;
    assign status.end_flag  = end_reg;
    assign status.bt_last   = (p_reg == '0);
    assign status.em_last   = (e_reg == wc_m1[PW-1:0]);

    // unwritten entries and out-of-vocabulary words read as the floor
    assign tr_v = tr_rd_reg[32] ? tr_rd_reg[31:0] : floor_reg;
    assign em_v = (known_reg & em_rd_reg[32]) ? em_rd_reg[31:0] : floor_reg;
    assign pr_v = (known_reg & pr_rd_reg[32]) ? pr_rd_reg[31:0] : floor_reg;

    assign sum_w = (SW+1)'(pa2_reg) + (SW+1)'(te_reg);
    assign sat_v = (sum_w[SW] != sum_w[SW-1]) ? (sum_w[SW] ? SCORE_MIN : SCORE_MAX)
                                              : sum_w[SW-1:0];
    assign t_next = wc_zero ? SW'(pr2_reg) : sat_v;

    // strict compare keeps the lowest index on a tie
    assign take  = f3_reg | (t_reg > best_reg);
    assign nbest = take ? t_reg : best_reg;
    assign narg  = take ? k3_reg : arg_reg;
    assign stake = sf1_reg | (pa_rd_reg > mx_reg);
    assign nmx   = stake ? pa_rd_reg : mx_reg;
    assign nsarg = stake ? sk1_reg : tag_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            tr_mem[tr_waddr] <= wdata;
        end
        if (em_we)
        begin
            em_mem[tb_waddr_e] <= wdata;
        end
        if (pr_we)
        begin
            pr_mem[tb_waddr_e] <= wdata;
        end
        if (v3_reg && l3_reg)
        begin
            pa_mem[{wc_reg[0], j3_reg}]     <= nbest;
            bp_mem[{wc_reg[PW-1:0], j3_reg}] <= narg;
        end
        if (cmd.bt_rd)
        begin
            tb_mem[p_reg] <= tag_reg;
        end
        tr_rd_reg <= tr_mem[{j_reg, k_reg}];
        em_rd_reg <= em_mem[{j_reg, word_reg}];
        pr_rd_reg <= pr_mem[{j_reg, word_reg}];
        pa_rd_reg <= pa_mem[pa_raddr];
        bp_rd_reg <= bp_mem[{p_reg, tag_reg}];
        tb_rd_reg <= tb_mem[e_reg];
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.push_take)
        begin
            word_reg  <= word_a;
            known_reg <= word_ok;
        end
        j1_reg  <= j_reg;
        k1_reg  <= k_reg;
        sk1_reg <= k_reg;
        j2_reg  <= j1_reg;
        k2_reg  <= k1_reg;
        j3_reg  <= j2_reg;
        k3_reg  <= k2_reg;
        te_reg  <= 33'(tr_v) + 33'(em_v);
        pa2_reg <= pa_rd_reg;
        pr2_reg <= pr_v;
        t_reg   <= t_next;
        if (v3_reg)
        begin
            best_reg <= nbest;
            arg_reg  <= narg;
        end
        if (sv1_reg)
        begin
            mx_reg <= nmx;
        end
        if (cmd.em_load)
        begin
            tag_index_reg <= 6'(tb_rd_reg);
            word_pos_reg  <= 6'(e_reg);
            last_tag_reg  <= status.em_last;
            ovf_out_reg   <= ovf_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg     <= FLOOR_RESET;
            clr_reg       <= '0;
            wc_reg        <= '0;
            ovf_reg       <= 1'b0;
            end_reg       <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            f1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            f2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            l3_reg        <= 1'b0;
            f3_reg        <= 1'b0;
            sv1_reg       <= 1'b0;
            sf1_reg       <= 1'b0;
            tag_reg       <= '0;
            p_reg         <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                floor_reg <= cfg_data;
            end
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + CLRW'(1);
            end
            if (cmd.push_take)
            begin
                end_reg <= sentence_end;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.word_done)
            begin
                wc_reg <= wc_reg + CW'(1);
            end
            if (cmd.acs_issue)
            begin
                if (k_last)
                begin
                    k_reg <= '0;
                    j_reg <= (j_reg == LAST_TAG) ? '0 : j_reg + TW'(1);
                end
                else
                begin
                    k_reg <= k_reg + TW'(1);
                end
            end
            else if (cmd.scan_issue)
            begin
                k_reg <= (k_reg == LAST_TAG) ? '0 : k_reg + TW'(1);
            end
            v1_reg  <= cmd.acs_issue;
            l1_reg  <= k_last;
            f1_reg  <= (k_reg == '0);
            v2_reg  <= v1_reg;
            l2_reg  <= l1_reg;
            f2_reg  <= f1_reg;
            v3_reg  <= v2_reg;
            l3_reg  <= l2_reg;
            f3_reg  <= f2_reg;
            sv1_reg <= cmd.scan_issue;
            sf1_reg <= (k_reg == '0);
            // running best tag of the final scan, then the tag walked by the backtrace
            if (sv1_reg)
            begin
                tag_reg <= nsarg;
            end
            else if (cmd.bt_step)
            begin
                tag_reg <= bp_rd_reg;
            end
            if (cmd.bt_init)
            begin
                p_reg <= wc_m1[PW-1:0];
            end
            else if (cmd.bt_step)
            begin
                p_reg <= p_reg - PW'(1);
            end
            if (cmd.em_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.sent_done)
            begin
                e_reg   <= '0;
                wc_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.em_next)
            begin
                e_reg <= e_reg + PW'(1);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign tag_index       = tag_index_reg;
    assign word_pos        = word_pos_reg;
    assign last_tag        = last_tag_reg;
    assign length_overflow = ovf_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/hmm_viterbi_decoder.sv
// top level of the log-domain hmm viterbi decoder
`default_nettype none

`include "hmm_viterbi_decoder_defines.svh"

// Log-domain Viterbi tagger. Table loads (transition, emission, prior) take
// one transfer each. After reset a clearing pass marks every table entry
// unwritten, and no input is taken meanwhile. The first word of a sentence
// visits each tag once; every later word steps the one add-compare-select
// unit through all current/previous tag pairs, using the single read port
// of the path score memory. On the sentence end the block scans the final
// scores, walks the backpointer memory and then presents one result per word,
// first word first, fetching the next result only after the previous one is
// taken. Input stays stalled until the last result is taken.
module hmm_viterbi_decoder
    import hvd_pkg::*;
#(
    parameter int NUM_TAGS    = 64,
    parameter int VOCAB_SIZE  = 4096,
    parameter int MAX_WORDS   = 64,
    parameter int SCORE_WIDTH = 48
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [31:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [5:0]         current_tag,
    input  wire logic [5:0]         previous_tag,
    input  wire logic [11:0]        word_index,
    input  wire logic signed [31:0] log_prob,
    input  wire logic               sentence_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [5:0]              tag_index,
    output logic [5:0]              word_pos,
    output logic                    last_tag,
    output logic                    length_overflow
);

    hvd_cmd_t    cmd;
    hvd_status_t status;

    assign cfg_ready = 1'b1;

    hvd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .sentence_end (sentence_end),
        .out_stall    (out_stall),
        .status       (status),
        .cmd          (cmd)
    );

    hvd_datapath #(
        .NUM_TAGS    (NUM_TAGS),
        .VOCAB_SIZE  (VOCAB_SIZE),
        .MAX_WORDS   (MAX_WORDS),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .func            (func),
        .current_tag     (current_tag),
        .previous_tag    (previous_tag),
        .word_index      (word_index),
        .log_prob        (log_prob),
        .sentence_end    (sentence_end),
        .out_valid       (out_valid),
        .tag_index       (tag_index),
        .word_pos        (word_pos),
        .last_tag        (last_tag),
        .length_overflow (length_overflow)
    );

    // no input transfer while a result is pending
    `HVD_ASSERT_NOW(a_no_in_while_out, !in_stall, !out_valid, "input open while result pending")
    // after the final result the block returns to idle
    `HVD_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && last_tag,
        !out_valid && !in_stall, "block not idle after final result")
    // inner results are followed by a fetch of the next result, input still stalled
    `HVD_ASSERT_NEXT(a_gap_after_take, out_valid && !out_stall && !last_tag,
        !out_valid && in_stall, "unexpected state after result transfer")

endmodule

`default_nettype wire
